FILE: design/bsa_pkg.sv
// Shared constants and codes of the bitmap slot allocator.
package bsa_pkg;

	localparam int SLOT_W = 12;

	localparam int DEF_GROUP_COUNT     = 64;
	localparam int DEF_SLOTS_PER_GROUP = 64;

	localparam logic FUNC_ANY      = 1'b0;
	localparam logic FUNC_SPECIFIC = 1'b1;

endpackage

FILE: design/bsa_req_if.sv
// Request channel of the bitmap slot allocator.
interface bsa_req_if import bsa_pkg::*; ;
	logic              valid;
	logic              ready;
	logic              func;
	logic [SLOT_W-1:0] requested_slot;

	modport source (output valid, output func, output requested_slot, input ready);
	modport sink (input valid, input func, input requested_slot, output ready);
endinterface

FILE: design/bsa_rsp_if.sv
// Response channel of the bitmap slot allocator.
interface bsa_rsp_if import bsa_pkg::*; ;
	logic              valid;
	logic              ready;
	logic              granted;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, output granted, output slot_index, input ready);
	modport sink (input valid, input granted, input slot_index, output ready);
endinterface

FILE: design/bitmap_slot_allocator_unit.sv
// Bitmap slot allocator: grants free slots from a pool kept as a memory of per-group free bits.
//
// After reset the block sets every word of the bitmap memory to all ones and accepts no
// request meanwhile. For each request the accept cycle then picks the group (a priority
// search over a register of non-empty group flags for an "any" request, a reciprocal
// multiply for a named slot) and reads the bitmap word; the work state, once the result
// register is empty or its response is taken, finds the bit, writes the word back and
// loads the result register. The block takes a new request while the previous result
// waits, so a stalled response holds the pipe only after one more request has entered.
module bitmap_slot_allocator_unit import bsa_pkg::*; #(
	parameter int GROUP_COUNT     = DEF_GROUP_COUNT,
	parameter int SLOTS_PER_GROUP = DEF_SLOTS_PER_GROUP
) (
	input  logic      clk,
	input  logic      arst_n,
	bsa_req_if.sink   req,
	bsa_rsp_if.source rsp
);

	localparam int GW     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int HW     = $clog2(GROUP_COUNT + 1);
	localparam int BW     = $clog2(SLOTS_PER_GROUP);
	localparam int MW     = 14;
	localparam int PW     = SLOT_W + MW;
	localparam int SW     = GW + BW + 1;
	localparam int RECIP  = ((1 << (SLOT_W + BW)) + SLOTS_PER_GROUP - 1) / SLOTS_PER_GROUP;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_WORK = 2'd2;

	logic [SLOTS_PER_GROUP-1:0] mem [GROUP_COUNT];

	logic [1:0]                 state_q;
	logic [GW-1:0]              init_q;
	logic [GROUP_COUNT-1:0]     summary_q;
	logic [HW-1:0]              hint_q;

	logic                       func_s1;
	logic [SLOT_W-1:0]          slot_s1;
	logic [SLOT_W-1:0]          quot_s1;
	logic [GW-1:0]              grp_s1;
	logic                       ok_s1;
	logic [SLOTS_PER_GROUP-1:0] word_s1;

	logic                       out_valid_q;
	logic                       granted_q;
	logic [SLOT_W-1:0]          slot_q;

	logic                       accept;
	logic                       advance;
	logic [PW-1:0]              prod;
	logic [SLOT_W-1:0]          quot;
	logic                       any_hit;
	logic [GW-1:0]              any_grp;
	logic [GW-1:0]              rd_addr;
	logic [BW-1:0]              low_bit;
	logic [BW-1:0]              spec_bit;
	logic [BW-1:0]              sel_bit;
	logic                       hit;
	logic [SLOTS_PER_GROUP-1:0] new_word;
	logic                       wr_en;
	logic [GW-1:0]              wr_addr;
	logic [SLOTS_PER_GROUP-1:0] wr_data;
	logic [SLOT_W-1:0]          any_slot;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign advance   = (state_q == ST_WORK) && (!out_valid_q || rsp.ready);

	// slot / SLOTS_PER_GROUP, exact for 12-bit slots
	assign prod = PW'(req.requested_slot) * PW'(RECIP);
	assign quot = SLOT_W'(prod >> (SLOT_W + BW));

	always_comb begin
		any_hit = 1'b0;
		any_grp = '0;
		for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
			if (summary_q[i] && (HW'(i) >= hint_q)) begin
				any_hit = 1'b1;
				any_grp = GW'(i);
			end
		end
	end

	assign rd_addr = (req.func == FUNC_ANY) ? any_grp : GW'(quot);

	always_comb begin
		low_bit = '0;
		for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
			if (word_s1[i]) begin
				low_bit = BW'(i);
			end
		end
	end

	assign spec_bit = BW'(slot_s1 - SLOT_W'(quot_s1 * SLOT_W'(SLOTS_PER_GROUP)));
	assign sel_bit  = (func_s1 == FUNC_ANY) ? low_bit : spec_bit;
	assign hit      = (func_s1 == FUNC_ANY) ? ok_s1 : (ok_s1 && word_s1[sel_bit]);
	assign new_word = word_s1 & ~(SLOTS_PER_GROUP'(1) << sel_bit);
	assign any_slot = SLOT_W'(SW'(grp_s1) * SW'(SLOTS_PER_GROUP) + SW'(sel_bit));

	assign wr_en   = (state_q == ST_INIT) || (advance && hit);
	assign wr_addr = (state_q == ST_INIT) ? init_q : grp_s1;
	assign wr_data = (state_q == ST_INIT) ? '1 : new_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			slot_s1 <= req.requested_slot;
			quot_s1 <= quot;
			grp_s1  <= rd_addr;
			ok_s1   <= (req.func == FUNC_ANY) ? any_hit : (quot < SLOT_W'(GROUP_COUNT));
		end
		if (advance) begin
			granted_q <= hit;
			if (!hit) begin
				slot_q <= '0;
			end else if (func_s1 == FUNC_ANY) begin
				slot_q <= any_slot;
			end else begin
				slot_q <= slot_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			summary_q   <= '1;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + GW'(1);
					if (init_q == GW'(GROUP_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (advance) begin
						state_q <= ST_IDLE;
						if (hit) begin
							summary_q[grp_s1] <= |new_word;
							if ((HW'(grp_s1) == hint_q) && (new_word == '0)) begin
								hint_q <= HW'(grp_s1) + HW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.granted    = granted_q;
	assign rsp.slot_index = slot_q;

endmodule
